>>> rtl/msl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msl_pkg;

    localparam int AXES        = 4;
    localparam int AXIS_W      = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int CH_W        = $clog2(AXES + 1);
    localparam int MIN_REGS    = 4;

    localparam int POS_W       = 16;
    localparam int LIM_W       = 12;
    localparam int STEP_W      = 8;
    localparam int IDX_W       = 2;
    localparam int CHAN_W      = 4;
    localparam int ADDR_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int ARITH_W     = POS_W + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LIM_W-1:0]  OFF_MAX   = 12'd4095;
    localparam logic [POS_W-1:0]  POS_RESET = 16'd256;
    localparam logic [ADDR_W-1:0] REG_BASE  = 8'd6;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 3'd5;

    localparam logic [STEP_W-1:0] STEP_RESET  = 8'd2;
    localparam logic [LIM_W-1:0]  MIN0_RESET  = 12'd256;
    localparam logic [LIM_W-1:0]  MIN1_RESET  = 12'd140;
    localparam logic [LIM_W-1:0]  MIN2_RESET  = 12'd256;
    localparam logic [LIM_W-1:0]  MIN3_RESET  = 12'd256;
    localparam logic [LIM_W-1:0]  UPPER_RESET = 12'd512;

    typedef struct packed {
        logic              op;
        logic [AXIS_W-1:0] axis;
        logic [POS_W-1:0]  value;
    } msl_cmd_t;

    typedef struct packed {
        logic [STEP_W-1:0]               step;
        logic [MIN_REGS-1:0][LIM_W-1:0]  axis_min;
        logic [LIM_W-1:0]                upper;
    } msl_cfg_t;

endpackage

`default_nettype wire

>>> rtl/msl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module msl_front
    import msl_pkg::*;
(
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             opcode,
    input  wire logic [IDX_W-1:0] axis_index,
    input  wire logic [POS_W-1:0] target_value,
    input  wire logic             queue_full,
    output logic                  push,
    output msl_cmd_t              push_cmd
);

    logic axis_ok;

    // A set-target transaction for an axis that does not exist is dropped here.
    assign axis_ok  = (32'(axis_index) < AXES);
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full && ((opcode == OP_TICK) || axis_ok);

    always_comb
    begin
        push_cmd.op    = opcode;
        push_cmd.axis  = axis_index[AXIS_W-1:0];
        push_cmd.value = target_value;
    end

endmodule

`default_nettype wire

>>> rtl/msl_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module msl_cmd_queue
    import msl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire msl_cmd_t push_cmd,
    output logic          full,
    input  wire logic     pop,
    output msl_cmd_t      pop_cmd,
    output logic          empty
);

    msl_cmd_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/msl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module msl_back
    import msl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire msl_cfg_t cfg,
    input  wire logic     queue_empty,
    input  wire msl_cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [CHAN_W-1:0] out_chan,
    output logic [ADDR_W-1:0] out_addr,
    output logic [LIM_W-1:0]  out_off,
    output logic          out_last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg;
    logic              state_next;
    logic [CH_W-1:0]   ch_reg;
    logic [CH_W-1:0]   ch_next;
    logic [POS_W-1:0]  target_reg [AXES];
    logic [POS_W-1:0]  actual_reg [AXES];

    logic              ovalid_reg;
    logic              ovalid_next;
    logic [CHAN_W-1:0] ochan_reg;
    logic [ADDR_W-1:0] oaddr_reg;
    logic [LIM_W-1:0]  ooff_reg;
    logic              olast_reg;

    logic              out_free;
    logic              emit;
    logic              is_mirror;
    logic              is_last;
    logic [CH_W-1:0]   ch_minus;
    logic [AXIS_W-1:0] axis_sel;

    logic signed [ARITH_W-1:0] act_s;
    logic signed [ARITH_W-1:0] tgt_s;
    logic signed [ARITH_W-1:0] lo_s;
    logic signed [ARITH_W-1:0] hi_s;
    logic signed [ARITH_W-1:0] st_s;
    logic signed [ARITH_W-1:0] down_s;
    logic signed [ARITH_W-1:0] up_s;
    logic [POS_W-1:0]          new_act;
    logic [POS_W-1:0]          mirror;
    logic [POS_W-1:0]          frame_val;
    logic [LIM_W-1:0]          frame_off;
    logic [CHAN_W-1:0]         frame_chan;

    assign out_free  = !ovalid_reg || out_ready;
    assign pop       = (state_reg == ST_IDLE) && !queue_empty;
    assign emit      = (state_reg == ST_RUN) && out_free;
    assign is_mirror = (ch_reg == CH_W'(1));
    assign is_last   = (ch_reg == CH_W'(AXES));
    assign ch_minus  = ch_reg - 1'b1;
    assign axis_sel  = (ch_reg == '0) ? '0 : ch_minus[AXIS_W-1:0];

    // Move one axis toward its target, first downward then upward, as in a tick.
    always_comb
    begin
        act_s  = ARITH_W'(actual_reg[axis_sel]);
        tgt_s  = ARITH_W'(target_reg[axis_sel]);
        lo_s   = ARITH_W'(cfg.axis_min[axis_sel]);
        hi_s   = ARITH_W'(cfg.upper);
        st_s   = ARITH_W'(cfg.step);
        down_s = act_s;
        if ((act_s > tgt_s) && (act_s > lo_s))
        begin
            down_s = act_s - st_s;
            if (down_s < tgt_s)
            begin
                down_s = tgt_s;
            end
            if (down_s < lo_s)
            begin
                down_s = lo_s;
            end
        end
        up_s = down_s;
        if ((down_s < tgt_s) && (down_s < hi_s))
        begin
            up_s = down_s + st_s;
            if (up_s > tgt_s)
            begin
                up_s = tgt_s;
            end
            if (up_s > hi_s)
            begin
                up_s = hi_s;
            end
        end
        new_act = up_s[POS_W-1:0];
    end

    assign mirror     = POS_W'(cfg.upper) + POS_W'(cfg.axis_min[0]) - actual_reg[0];
    assign frame_val  = is_mirror ? mirror : new_act;
    assign frame_off  = (frame_val > POS_W'(OFF_MAX)) ? OFF_MAX : frame_val[LIM_W-1:0];
    assign frame_chan = CHAN_W'(ch_reg);

    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        ovalid_next = ovalid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && (head_cmd.op == OP_TICK))
                begin
                    state_next = ST_RUN;
                    ch_next    = '0;
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    ovalid_next = 1'b1;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ch_next = ch_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ch_reg     <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                target_reg[i] <= POS_RESET;
                actual_reg[i] <= POS_RESET;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            ovalid_reg <= ovalid_next;
            if (pop && (head_cmd.op == OP_SET))
            begin
                target_reg[head_cmd.axis] <= head_cmd.value;
            end
            if (emit && !is_mirror)
            begin
                actual_reg[axis_sel] <= new_act;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ochan_reg <= frame_chan;
            oaddr_reg <= REG_BASE + ADDR_W'({frame_chan, 2'b00});
            ooff_reg  <= frame_off;
            olast_reg <= is_last;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_chan  = ochan_reg;
    assign out_addr  = oaddr_reg;
    assign out_off   = ooff_reg;
    assign out_last  = olast_reg;

endmodule

`default_nettype wire

>>> rtl/multi_axis_servo_slew_limiter.sv
// Servo slew limiter for four axes. A set-target transaction (tuser low) is queued and
// then updates its axis target in the back end; it gives no output. A tick transaction
// (tuser high) leaves the command queue and then yields five output frames, because a
// single shared update unit moves one axis toward its target per cycle while the output
// is not stalled. Frames come out on channels 0 to 4, channel 1 carrying the mirror of
// axis 0, and tlast marks the fifth. The two-entry command queue lets new transactions
// be taken while a tick is still sending frames. Configuration writes take effect at once
// and should be made only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module multi_axis_servo_slew_limiter
    import msl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [LIM_W-1:0]     cfg_wdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [23:0]          s_axis_tdata,  // axis_index, target_value, zero pad
    input  wire logic                 s_axis_tuser,  // opcode
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [23:0]               m_axis_tdata,  // pwm_channel, register_address, off_count
    output logic                      m_axis_tlast
);

    msl_cfg_t  cfg_reg;
    logic      push;
    msl_cmd_t  push_cmd;
    logic      queue_full;
    logic      queue_empty;
    logic      pop;
    msl_cmd_t  head_cmd;

    logic [CHAN_W-1:0] out_chan;
    logic [ADDR_W-1:0] out_addr;
    logic [LIM_W-1:0]  out_off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step        <= STEP_RESET;
            cfg_reg.axis_min[0] <= MIN0_RESET;
            cfg_reg.axis_min[1] <= MIN1_RESET;
            cfg_reg.axis_min[2] <= MIN2_RESET;
            cfg_reg.axis_min[3] <= MIN3_RESET;
            cfg_reg.upper       <= UPPER_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                CFG_STEP:  cfg_reg.step        <= cfg_wdata[STEP_W-1:0];
                CFG_MIN0:  cfg_reg.axis_min[0] <= cfg_wdata;
                CFG_MIN1:  cfg_reg.axis_min[1] <= cfg_wdata;
                CFG_MIN2:  cfg_reg.axis_min[2] <= cfg_wdata;
                CFG_MIN3:  cfg_reg.axis_min[3] <= cfg_wdata;
                CFG_UPPER: cfg_reg.upper       <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    msl_front u_front (
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .opcode       (s_axis_tuser),
        .axis_index   (s_axis_tdata[IDX_W-1:0]),
        .target_value (s_axis_tdata[IDX_W+POS_W-1:IDX_W]),
        .queue_full   (queue_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    msl_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .pop_cmd  (head_cmd),
        .empty    (queue_empty)
    );

    msl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_chan    (out_chan),
        .out_addr    (out_addr),
        .out_off     (out_off),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {out_off, out_addr, out_chan};

endmodule

`default_nettype wire
